/* hdl/sfdu_pkg.sv */
`timescale 1ns / 1ps

package sfdu_pkg;

  localparam logic [7:0] ESC_BYTE  = 8'h19;
  localparam logic [7:0] FLAG_GOOD = 8'hB1;
  localparam logic [7:0] FLAG_BAD  = 8'hB2;

  localparam logic [7:0] D_19 = 8'h19;
  localparam logic [7:0] D_99 = 8'h99;
  localparam logic [7:0] D_11 = 8'h11;
  localparam logic [7:0] D_13 = 8'h13;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       run_last;
    logic       err;
    logic       last;
    logic       first;
    logic [7:0] data;
  } res_t;

  // up to two results produced by one accepted request
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] a;
    logic [7:0] b;
  } esc_t;

  function automatic esc_t decode_code(input logic [7:0] c);
    esc_t e;
    e = '{cnt: 2'd2, a: 8'h00, b: 8'h00};
    unique case (c)
      8'h5C: begin e.cnt = 2'd1; e.a = D_19; end
      8'h76: begin e.cnt = 2'd1; e.a = D_99; end
      8'hA0: begin e.cnt = 2'd1; e.a = D_11; end
      8'hA1: begin e.cnt = 2'd1; e.a = D_13; end
      8'h5D: begin e.a = D_19; e.b = D_19; end
      8'h77: begin e.a = D_99; e.b = D_99; end
      8'hA2: begin e.a = D_11; e.b = D_11; end
      8'hA3: begin e.a = D_13; e.b = D_13; end
      8'hA4: begin e.a = D_19; e.b = D_99; end
      8'hA5: begin e.a = D_19; e.b = D_11; end
      8'hA6: begin e.a = D_19; e.b = D_13; end
      8'hA7: begin e.a = D_99; e.b = D_19; end
      8'hA8: begin e.a = D_99; e.b = D_11; end
      8'hA9: begin e.a = D_99; e.b = D_13; end
      8'hAA: begin e.a = D_11; e.b = D_19; end
      8'hAB: begin e.a = D_11; e.b = D_99; end
      8'hAC: begin e.a = D_11; e.b = D_13; end
      8'hAD: begin e.a = D_13; e.b = D_19; end
      8'hAE: begin e.a = D_13; e.b = D_99; end
      8'hAF: begin e.a = D_13; e.b = D_11; end
      default: e.cnt = 2'd0;
    endcase
    return e;
  endfunction

endpackage

/* hdl/sfdu_decode.sv */
`timescale 1ns / 1ps

module sfdu_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  input  logic          in_fire,
  input  logic [7:0]    rx_byte,
  input  logic          chunk_last,
  output sfdu_pkg::push_t push
);

  logic [7:0] addr_r;
  logic       in_frame_r, in_frame_nxt;
  logic       esc_r, esc_nxt;
  logic       drop_r, drop_nxt;
  sfdu_pkg::esc_t code;
  sfdu_pkg::push_t p;

  always_comb begin
    code         = sfdu_pkg::decode_code(rx_byte);
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    drop_nxt     = drop_r;
    p            = '0;

    if (drop_r) begin
      if (chunk_last) drop_nxt = 1'b0;
    end else if (!in_frame_r) begin
      if (rx_byte == addr_r) begin
        in_frame_nxt = 1'b1;
        esc_nxt      = 1'b0;
        p.cnt        = 2'd1;
        p.r0.data    = rx_byte;
        p.r0.first   = 1'b1;
      end
    end else if (esc_r) begin
      if (rx_byte == sfdu_pkg::FLAG_GOOD || rx_byte == sfdu_pkg::FLAG_BAD) begin
        p.cnt        = 2'd2;
        p.r0.data    = sfdu_pkg::ESC_BYTE;
        p.r1.data    = rx_byte;
        p.r1.last    = 1'b1;
        p.r1.err     = (rx_byte == sfdu_pkg::FLAG_BAD);
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        drop_nxt     = !chunk_last;
      end else if (code.cnt != 2'd0) begin
        esc_nxt   = 1'b0;
        p.cnt     = code.cnt;
        p.r0.data = code.a;
        p.r1.data = code.b;
      end else begin
        p.r0.data = sfdu_pkg::ESC_BYTE;
        if (rx_byte == sfdu_pkg::ESC_BYTE) begin
          // second escape stays pending
          p.cnt = 2'd1;
        end else begin
          esc_nxt   = 1'b0;
          p.cnt     = 2'd2;
          p.r1.data = rx_byte;
        end
      end
    end else begin
      if (rx_byte == sfdu_pkg::ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        p.cnt     = 2'd1;
        p.r0.data = rx_byte;
      end
    end

    p.r0.run_last = (p.cnt == 2'd1);
    p.r1.run_last = (p.cnt == 2'd2);
    push = p;
    if (!in_fire) push.cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= 8'h00;
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      drop_r     <= 1'b0;
    end else begin
      if (cfg_we) addr_r <= cfg_data;
      if (in_fire) begin
        in_frame_r <= in_frame_nxt;
        esc_r      <= esc_nxt;
        drop_r     <= drop_nxt;
      end
    end
  end

endmodule

/* hdl/sfdu_outq.sv */
`timescale 1ns / 1ps

module sfdu_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  sfdu_pkg::push_t push,
  output logic            room,
  output logic            q_valid,
  input  logic            q_pop,
  output sfdu_pkg::res_t  q_head
);

  sfdu_pkg::res_t              q_r [sfdu_pkg::QDEPTH];
  logic [sfdu_pkg::QAW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [sfdu_pkg::QAW:0]      count_r, count_nxt;
  logic [sfdu_pkg::QAW-1:0]    wr_ptr1;
  logic                        pop;

  assign pop     = q_pop && q_valid;
  assign q_valid = (count_r != '0);
  // room for the worst case of two results
  assign room    = (count_r <= (sfdu_pkg::QAW + 1)'(sfdu_pkg::QDEPTH - 2));
  assign q_head  = q_r[rd_ptr_r];
  assign wr_ptr1 = wr_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r + (sfdu_pkg::QAW + 1)'(push.cnt) - (sfdu_pkg::QAW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) q_r[wr_ptr1]  <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + sfdu_pkg::QAW'(push.cnt);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/sync_frame_deframer_unescaper.sv */
`timescale 1ns / 1ps

// Receive deframer and transparency decoder for a synchronous modem link.
// Raw modem bytes come in on the in_ stream (tlast marks the end of a chunk).
// While hunting, bytes are dropped until one equals the station address,
// written through the cfg_ channel (reset value 0x00, write only while idle).
// Inside a frame, 0x19 escapes are decoded to one or two data bytes, and
// 0x19 0xB1 / 0x19 0xB2 closes the frame, after which the rest of the chunk
// is dropped. One request is accepted per cycle when the queue has room for
// two results and yields zero, one or two results; a stalled output holds off
// the input once three results are waiting. Results enter a four-entry output
// queue at the accepting edge and show on out_ from the next cycle, one per
// cycle while out_tready is high. Each pair follows an escape byte that
// yields nothing (a re-held escape between them yields one), so with
// out_tready held high the input takes a byte every cycle.
module sync_frame_deframer_unescaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,   // station_address
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte
  input  logic       in_tlast,   // chunk_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // data_byte
  output logic       out_tlast,  // frame_last
  output logic [2:0] out_tuser   // [0] frame_first, [1] frame_error, [2] run_last
);

  sfdu_pkg::push_t push;
  sfdu_pkg::res_t  head;
  logic            room;
  logic            in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign in_fire   = in_tvalid && room;

  sfdu_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .rx_byte    (in_tdata),
    .chunk_last (in_tlast),
    .push       (push)
  );

  sfdu_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .q_valid (out_tvalid),
    .q_pop   (out_tready),
    .q_head  (head)
  );

  assign out_tdata = head.data;
  assign out_tlast = head.last;
  assign out_tuser = {head.run_last, head.err, head.first};

endmodule

/* bench/sync_frame_deframer_unescaper_tb.sv */
`timescale 1ns / 1ps

class frame_checker;
  // escape code bytes, index order matches the decoded symbol order below
  localparam logic [3:0][7:0] SINGLE_CODES = {8'hA1, 8'hA0, 8'h76, 8'h5C};
  localparam logic [3:0][7:0] DOUBLE_CODES = {8'hA3, 8'hA2, 8'h77, 8'h5D};
  localparam logic [7:0]      PAIR_BASE    = 8'hA4;
  localparam logic [7:0]      PAIR_TOP     = 8'hAF;
  localparam logic [3:0][7:0] SYMBOLS      = {sfdu_pkg::D_13, sfdu_pkg::D_11,
                                              sfdu_pkg::D_99, sfdu_pkg::D_19};

  logic [7:0]      station_addr;
  bit              in_frame;
  bit              esc_held;
  bit              dropping;
  sfdu_pkg::res_t  decoded_q[$];
  int unsigned     fails;

  function new();
    station_addr = 8'h00;
    in_frame     = 0;
    esc_held     = 0;
    dropping     = 0;
    fails        = 0;
  endfunction

  // i in 0..19: singles, then doubles, then the twelve mixed pairs
  static function logic [7:0] code_byte(int unsigned i);
    if (i < 4) return SINGLE_CODES[i];
    if (i < 8) return DOUBLE_CODES[i-4];
    return PAIR_BASE + 8'(i - 8);
  endfunction

  function int unsigned unescape(input logic [7:0] c, output logic [7:0] a,
                                 output logic [7:0] b);
    int unsigned k;
    int unsigned j;
    a = 8'h00;
    b = 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (c == SINGLE_CODES[i]) begin
        a = SYMBOLS[i];
        return 1;
      end
      if (c == DOUBLE_CODES[i]) begin
        a = SYMBOLS[i];
        b = SYMBOLS[i];
        return 2;
      end
    end
    if (c < PAIR_BASE || c > PAIR_TOP) return 0;
    // mixed pair: first symbol, then one of the three others in order
    k = int'(c - PAIR_BASE);
    j = k % 3;
    a = SYMBOLS[k / 3];
    b = (j < k / 3) ? SYMBOLS[j] : SYMBOLS[j + 1];
    return 2;
  endfunction

  function sfdu_pkg::res_t entry(logic [7:0] d, logic f, logic l, logic e);
    sfdu_pkg::res_t x;
    x = '0;
    x.data  = d;
    x.first = f;
    x.last  = l;
    x.err   = e;
    return x;
  endfunction

  // predicts the decoded bytes for one accepted request, returns their count
  function int unsigned note_rx_byte(logic [7:0] b, logic chunk_end);
    sfdu_pkg::res_t r[2];
    int unsigned    n;
    int unsigned    cnt;
    logic [7:0]     a;
    logic [7:0]     c;
    n = 0;
    if (dropping) begin
      if (chunk_end) dropping = 0;
      return 0;
    end
    if (!in_frame) begin
      if (b == station_addr) begin
        in_frame = 1;
        esc_held = 0;
        r[0] = entry(b, 1'b1, 1'b0, 1'b0);
        n = 1;
      end
    end else if (esc_held) begin
      if (b == sfdu_pkg::FLAG_GOOD || b == sfdu_pkg::FLAG_BAD) begin
        r[0] = entry(sfdu_pkg::ESC_BYTE, 1'b0, 1'b0, 1'b0);
        r[1] = entry(b, 1'b0, 1'b1, b == sfdu_pkg::FLAG_BAD);
        n = 2;
        in_frame = 0;
        esc_held = 0;
        dropping = !chunk_end;
      end else begin
        cnt = unescape(b, a, c);
        if (cnt > 0) begin
          esc_held = 0;
          r[0] = entry(a, 1'b0, 1'b0, 1'b0);
          r[1] = entry(c, 1'b0, 1'b0, 1'b0);
          n = cnt;
        end else begin
          r[0] = entry(sfdu_pkg::ESC_BYTE, 1'b0, 1'b0, 1'b0);
          n = 1;
          // a second escape byte becomes the new held escape
          if (b != sfdu_pkg::ESC_BYTE) begin
            esc_held = 0;
            r[1] = entry(b, 1'b0, 1'b0, 1'b0);
            n = 2;
          end
        end
      end
    end else if (b == sfdu_pkg::ESC_BYTE) begin
      esc_held = 1;
    end else begin
      r[0] = entry(b, 1'b0, 1'b0, 1'b0);
      n = 1;
    end
    for (int unsigned i = 0; i < n; i++) begin
      r[i].run_last = (i == n - 1);
      decoded_q.push_back(r[i]);
    end
    return n;
  endfunction

  function void check_decoded(logic [7:0] data, logic tlast, logic [2:0] user);
    sfdu_pkg::res_t e;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: data_byte %h tlast %b tuser %b", data, tlast, user);
      fails++;
      return;
    end
    e = decoded_q.pop_front();
    if (data !== e.data) begin
      $error("data_byte: expected %h, got %h", e.data, data);
      fails++;
    end
    if (user[0] !== e.first) begin
      $error("frame_first: expected %b, got %b", e.first, user[0]);
      fails++;
    end
    if (tlast !== e.last) begin
      $error("frame_last: expected %b, got %b", e.last, tlast);
      fails++;
    end
    if (user[1] !== e.err) begin
      $error("frame_error: expected %b, got %b", e.err, user[1]);
      fails++;
    end
    if (user[2] !== e.run_last) begin
      $error("run_last: expected %b, got %b", e.run_last, user[2]);
      fails++;
    end
  endfunction
endclass

module sync_frame_deframer_unescaper_tb;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned PHASE_ITEMS   = 215;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data   = 8'h00;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [2:0] out_tuser;

  frame_checker chk = new();

  int unsigned burst_left = 0;
  int unsigned phase_sent = 0;
  int unsigned hold_cnt   = 0;
  bit          hold_req   = 0;
  int unsigned idle_cycles = 0;

  sync_frame_deframer_unescaper u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),    // station_address
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // rx_byte
    .in_tlast   (in_tlast),    // chunk_last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // data_byte
    .out_tlast  (out_tlast),   // frame_last
    .out_tuser  (out_tuser)    // [0] frame_first, [1] frame_error, [2] run_last
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: checks results and stalls on a pattern that changes mode
  int unsigned rx_mode  = 0;
  int unsigned rx_left  = 0;
  int unsigned rx_tick  = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      chk.check_decoded(out_tdata, out_tlast, out_tuser);
    rx_tick++;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= (rx_tick % 4 == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // no gaps while the receiver is held off, so the block backs up
      if (hold_req || hold_cnt != 0 || $urandom_range(0, 3) == 0)
        gap = 0;
      else
        gap = $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    void'(chk.note_rx_byte(b, l));
    phase_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (chk.decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chk.station_addr = v;
  endtask

  task automatic send_random_chunk();
    int unsigned kind;
    int unsigned cnt;
    int unsigned sel;
    logic [7:0]  b;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // noise, with escapes, the good flag and the address mixed in
      cnt = $urandom_range(1, 12);
      for (int unsigned i = 0; i < cnt; i++) begin
        sel = $urandom_range(0, 7);
        b = (sel == 0) ? sfdu_pkg::ESC_BYTE :
            (sel == 1) ? chk.station_addr :
            (sel == 2) ? sfdu_pkg::FLAG_GOOD : 8'($urandom_range(0, 255));
        send_byte(b, $urandom_range(0, 5) == 0);
      end
      return;
    end
    cnt = $urandom_range(0, 3);
    for (int unsigned i = 0; i < cnt; i++)
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(chk.station_addr, 1'b0);
    cnt = $urandom_range(0, 10);
    for (int unsigned i = 0; i < cnt; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel < 7) begin
        send_byte(sfdu_pkg::ESC_BYTE, $urandom_range(0, 7) == 0);
        send_byte(chk.code_byte($urandom_range(0, 19)), 1'b0);
      end else if (sel == 7) begin
        send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel == 8) begin
        send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
        send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
      end else begin
        // frame continues into the next chunk
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    if (kind == 1) begin
      // left open
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    cnt = $urandom_range(0, 3);
    send_byte(sfdu_pkg::ESC_BYTE, $urandom_range(0, 9) == 0);
    send_byte($urandom_range(0, 1) ? sfdu_pkg::FLAG_BAD : sfdu_pkg::FLAG_GOOD,
              cnt == 0);
    for (int unsigned i = 0; i < cnt; i++)
      send_byte(8'($urandom_range(0, 255)), i == cnt - 1);
  endtask

  initial begin
    logic [7:0] addr_list[5];
    addr_list = '{8'hFF, 8'($urandom_range(0, 255)), 8'h00, sfdu_pkg::ESC_BYTE,
                  8'($urandom_range(0, 255))};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset address 0x00
    send_byte(8'h55, 1'b0);                  // ignored while hunting
    send_byte(8'h00, 1'b0);                  // opens the frame
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
    send_byte(chk.code_byte(0), 1'b0);       // single byte code
    send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
    send_byte(chk.code_byte(8), 1'b0);       // first mixed pair
    send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
    send_byte(8'h42, 1'b0);                  // not a code, passed through
    send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
    send_byte(sfdu_pkg::ESC_BYTE, 1'b0);     // escape re-held
    send_byte(chk.code_byte(4), 1'b0);       // doubled code
    send_byte(sfdu_pkg::ESC_BYTE, 1'b1);     // escape held across the chunk end
    send_byte(chk.code_byte(19), 1'b0);      // last mixed pair
    send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
    send_byte(sfdu_pkg::FLAG_GOOD, 1'b0);    // close mid-chunk, rest dropped
    send_byte(8'h77, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
    send_byte(sfdu_pkg::FLAG_BAD, 1'b1);     // errored close on the chunk end
    drain();

    // address equal to the escape byte
    write_address(sfdu_pkg::ESC_BYTE);
    send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
    send_byte(chk.code_byte(0), 1'b0);
    send_byte(sfdu_pkg::ESC_BYTE, 1'b0);
    send_byte(sfdu_pkg::FLAG_GOOD, 1'b1);

    foreach (addr_list[p]) begin
      drain();
      write_address(addr_list[p]);
      if (p == 1) hold_req = 1;
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) send_random_chunk();
    end

    drain();
    if (chk.fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
